// ----- rtl/core/wam_pkg.sv -----
// Shared types, codes and constants of the weekly alarm matcher.
`timescale 1ns / 1ps
`default_nettype none
package wam_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] REG_ALARM_COUNT   = 2'd0;
  localparam logic [1:0] REG_BUZZER_ENABLE = 2'd1;
  localparam logic [1:0] REG_RING_DURATION = 2'd2;

  localparam logic [4:0]  ALARM_COUNT_RST   = 5'd0;
  localparam logic        BUZZER_RST        = 1'b1;
  localparam logic [23:0] RING_DURATION_RST = 24'd60000;

  localparam logic [4:0]  SLOT_NONE   = 5'd31;
  localparam logic [8:0]  DAY_NEVER   = 9'd511;
  localparam logic [6:0]  MINUTE_NONE = 7'd127;
  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [8:0] last_day;
    logic       single_shot;
    logic [6:0] day_mask;
    logic [5:0] minute;
    logic [4:0] hour;
  } entry_t;

  function automatic logic [2:0] day_bit(input logic [2:0] weekday);
    logic [2:0] b;
    case (weekday)
      3'd0: b = 3'd6;
      3'd1: b = 3'd0;
      3'd2: b = 3'd1;
      3'd3: b = 3'd2;
      3'd4: b = 3'd3;
      3'd5: b = 3'd4;
      3'd6: b = 3'd5;
      default: b = 3'd6;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/weekly_alarm_matcher_top.sv -----
// Top level of the weekly alarm matcher: entry table, minute scan and ring timer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one command item at a time and returns one result item for it. A write,
// a millisecond tick, a minute check that is skipped or an unused command passes
// through the EXEC and OUT states before its result is registered. A minute check
// that runs scans the entry table from index zero, one entry per cycle through
// the table RAM's single read port. It scans up to the number of entries in use,
// where that number is alarm_count capped at MAX_ALARMS, and it stops early at
// the first matching entry. s_tready is low from acceptance until the result
// has been loaded into the output register. The next item is then taken while
// that result still waits on m_tready. The entry enable bits clear at reset; the
// rest of the table needs no clearing.
module weekly_alarm_matcher_top
  import wam_pkg::*;
#(
  parameter int MAX_ALARMS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // entry_index, entry_enabled, entry_hour, entry_minute, entry_day_mask,
  // entry_single_shot, time_valid, now_hour, now_minute, now_weekday,
  // now_day_of_year
  input  wire logic [47:0] s_tdata,
  // command
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // fired, fired_index, ringing, ring_ended, store_dirty
  output logic [7:0]       m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam logic [6:0] MAX_N = 7'(MAX_ALARMS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [4:0]  alarm_count;
  logic        buzzer_enabled;
  logic [23:0] ring_duration_ms;

  logic [47:0] in_data;
  logic [1:0]  in_cmd;

  logic [MAX_ALARMS-1:0] slot_enabled;
  logic [6:0]  last_checked_minute;
  logic        ring_active;
  logic [4:0]  ring_slot;
  logic [23:0] ring_elapsed;
  logic        store_dirty;

  logic [6:0]  issue_idx;
  logic [6:0]  cmp_idx;
  logic        cmp_v;

  logic        res_fired;
  logic [3:0]  res_idx;
  logic        res_ended;

  logic        out_valid;
  logic [7:0]  out_data;

  // input field decode
  logic [3:0] f_index;
  logic       f_enabled;
  logic [4:0] f_hour;
  logic [5:0] f_minute;
  logic [6:0] f_mask;
  logic       f_single;
  logic       f_time_valid;
  logic [4:0] f_now_hour;
  logic [5:0] f_now_minute;
  logic [2:0] f_now_weekday;
  logic [8:0] f_now_day;

  assign f_index       = in_data[3:0];
  assign f_enabled     = in_data[4];
  assign f_hour        = in_data[9:5];
  assign f_minute      = in_data[15:10];
  assign f_mask        = in_data[22:16];
  assign f_single      = in_data[23];
  assign f_time_valid  = in_data[24];
  assign f_now_hour    = in_data[29:25];
  assign f_now_minute  = in_data[35:30];
  assign f_now_weekday = in_data[38:36];
  assign f_now_day     = in_data[47:39];

  logic [6:0] used_n;
  assign used_n = ({2'b00, alarm_count} > MAX_N) ? MAX_N : {2'b00, alarm_count};

  logic write_ok;
  assign write_ok = ({3'b000, f_index} < MAX_N);

  logic check_run;
  assign check_run = f_time_valid && !ring_active && (used_n != 7'd0) &&
                     ({1'b0, f_now_minute} != last_checked_minute);

  // table RAM
  entry_t              rdata;
  entry_t              wdata;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    cmp_addr;
  logic [IDX_W-1:0]    ring_addr;
  logic [6:0]          ring_slot_w;

  assign cmp_addr    = cmp_idx[IDX_W-1:0];
  assign ring_slot_w = {2'b00, ring_slot};
  assign ring_addr   = ring_slot_w[IDX_W-1:0];
  assign raddr       = (state == ST_SCAN) ? issue_idx[IDX_W-1:0] : '0;

  logic [2:0] dbit;
  logic       hit;
  assign dbit = day_bit(f_now_weekday);
  assign hit  = cmp_v && slot_enabled[cmp_addr] && rdata.day_mask[dbit] &&
                (rdata.hour == f_now_hour) && (rdata.minute == f_now_minute) &&
                (rdata.last_day != f_now_day);

  logic exec_write;
  logic scan_fire;
  logic [6:0] write_idx_w;
  assign exec_write  = (state == ST_EXEC) && (in_cmd == CMD_WRITE) && write_ok;
  assign scan_fire   = (state == ST_SCAN) && hit;
  assign write_idx_w = {3'b000, f_index};

  always_comb begin
    we    = exec_write || scan_fire;
    waddr = exec_write ? write_idx_w[IDX_W-1:0] : cmp_addr;
    if (exec_write) begin
      wdata.last_day    = DAY_NEVER;
      wdata.single_shot = f_single;
      wdata.day_mask    = f_mask;
      wdata.minute      = f_minute;
      wdata.hour        = f_hour;
    end else begin
      wdata          = rdata;
      wdata.last_day = f_now_day;
    end
  end

  wam_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ALARMS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // ring timer
  logic [23:0] elapsed_inc;
  logic        ring_done;
  assign elapsed_inc = (ring_elapsed != ELAPSED_MAX) ? ring_elapsed + 24'd1 : ring_elapsed;
  assign ring_done   = elapsed_inc >= ring_duration_ms;

  logic out_free;
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (in_cmd == CMD_CHECK && check_run) state_next = ST_SCAN;
        else state_next = ST_OUT;
      end
      ST_SCAN: begin
        if (hit || !cmp_v) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_cmd  <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      alarm_count         <= ALARM_COUNT_RST;
      buzzer_enabled      <= BUZZER_RST;
      ring_duration_ms    <= RING_DURATION_RST;
      slot_enabled        <= '0;
      last_checked_minute <= MINUTE_NONE;
      ring_active         <= 1'b0;
      ring_slot           <= SLOT_NONE;
      ring_elapsed        <= '0;
      store_dirty         <= 1'b0;
      issue_idx           <= '0;
      cmp_idx             <= '0;
      cmp_v               <= 1'b0;
      res_fired           <= 1'b0;
      res_idx             <= '0;
      res_ended           <= 1'b0;
      out_valid           <= 1'b0;
      out_data            <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ALARM_COUNT:   alarm_count      <= cfg_data[4:0];
          REG_BUZZER_ENABLE: buzzer_enabled   <= cfg_data[0];
          REG_RING_DURATION: ring_duration_ms <= cfg_data;
          default: ;
        endcase
      end

      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
        out_data  <= {store_dirty, res_ended, ring_active, res_idx, res_fired};
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          res_fired <= 1'b0;
          res_idx   <= '0;
          res_ended <= 1'b0;
        end
        ST_EXEC: begin
          unique case (in_cmd)
            CMD_WRITE: begin
              if (write_ok) slot_enabled[write_idx_w[IDX_W-1:0]] <= f_enabled;
            end
            CMD_CHECK: begin
              if (check_run) begin
                last_checked_minute <= {1'b0, f_now_minute};
                issue_idx           <= 7'd1;
                cmp_idx             <= '0;
                cmp_v               <= 1'b1;
              end
            end
            CMD_TICK: begin
              if (ring_active) begin
                ring_elapsed <= elapsed_inc;
                if (ring_done) begin
                  ring_active <= 1'b0;
                  if (ring_slot_w < used_n) begin
                    slot_enabled[ring_addr] <= 1'b0;
                    store_dirty             <= 1'b1;
                  end
                  ring_slot <= SLOT_NONE;
                  res_ended <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (hit) begin
            if (rdata.single_shot) slot_enabled[cmp_addr] <= 1'b0;
            ring_elapsed <= '0;
            ring_slot    <= cmp_idx[4:0];
            store_dirty  <= 1'b1;
            if (buzzer_enabled) ring_active <= 1'b1;
            res_fired    <= 1'b1;
            res_idx      <= cmp_idx[3:0];
            cmp_v        <= 1'b0;
          end else begin
            cmp_idx   <= issue_idx;
            cmp_v     <= cmp_v && (issue_idx < used_n);
            issue_idx <= issue_idx + 7'd1;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/wam_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
